// File: design/esort_pkg.sv
// ----------------------------------------------------------------------------
// esort_pkg
// shared constants and types for the exchange sort engine
// ----------------------------------------------------------------------------
`default_nettype none

package esort_pkg;

    localparam int MAX_ELEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int DATA_W    = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_HEAD  = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_WB    = 7'b0010000,
        S_ORD   = 7'b0100000,
        S_OLD   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// File: design/exchange_sort_engine.sv
// sorting: a set of n >= 2 beats is sorted after its last beat, one compare per cycle
// with one read and one write port; each result beat then passes S_ORD and S_OLD
// throughput: one input beat per cycle while loading; bounded by the compare loop
// reset: asynchronous, active low; clears control, count and overflow flag,
// the element store is not cleared and holds undefined data until written
// ----------------------------------------------------------------------------
// exchange_sort_engine
// collects a set of signed words into a store, exchange-sorts it in place
// and streams the sorted run out with last and overflow marks
// ----------------------------------------------------------------------------
`default_nettype none

module exchange_sort_engine (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire  esort_pkg::word_t value,
    input  wire                   last_in,
    output logic                  out_valid,
    input  wire                   out_stall,
    output esort_pkg::word_t      sorted_value,
    output logic                  last_out,
    output logic                  overflow
);
    import esort_pkg::*;

    // element store
    word_t  store [MAX_ELEMS];
    word_t  rdata_reg;
    idx_t   rd_addr;
    logic   mem_we;
    idx_t   mem_waddr;
    word_t  mem_wdata;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    logic   ovf_reg, ovf_next;
    cnt_t   i_reg, i_next;
    cnt_t   j_reg, j_next;
    cnt_t   k_reg, k_next;
    word_t  cur_reg, cur_next;

    logic   out_valid_reg, out_valid_next;
    word_t  out_data_reg, out_data_next;
    logic   out_last_reg, out_last_next;
    logic   out_ovf_reg, out_ovf_next;

    logic   in_acc;
    logic   out_free;
    cnt_t   i_inc;
    cnt_t   j_inc;
    cnt_t   k_inc;
    cnt_t   load_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= store[rd_addr];
    end

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign i_inc     = i_reg + cnt_t'(1);
    assign j_inc     = j_reg + cnt_t'(1);
    assign k_inc     = k_reg + cnt_t'(1);
    assign load_cnt  = (cnt_reg < cnt_t'(MAX_ELEMS)) ? cnt_reg + cnt_t'(1) : cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        rd_addr        = k_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[IDX_W-1:0];
        mem_wdata      = value;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < cnt_t'(MAX_ELEMS))
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    cnt_next = load_cnt;
                    if (last_in)
                    begin
                        i_next = '0;
                        k_next = '0;
                        if (load_cnt >= cnt_t'(2))
                        begin
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_ORD;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cur_next   = rdata_reg;
                rd_addr    = i_inc[IDX_W-1:0];
                j_next     = i_inc;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // keep the smaller word at position i, push the larger back to j
                if (cur_reg > rdata_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg[IDX_W-1:0];
                    mem_wdata = cur_reg;
                    cur_next  = rdata_reg;
                end
                if (j_inc < cnt_reg)
                begin
                    rd_addr = j_inc[IDX_W-1:0];
                    j_next  = j_inc;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[IDX_W-1:0];
                mem_wdata = cur_reg;
                rd_addr   = i_inc[IDX_W-1:0];
                i_next    = i_inc;
                if (i_inc + cnt_t'(1) < cnt_reg)
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rdata_reg;
                    out_ovf_next   = ovf_reg;
                    if (k_inc == cnt_reg)
                    begin
                        out_last_next = 1'b1;
                        cnt_next      = '0;
                        ovf_next      = 1'b0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                        k_next        = k_inc;
                        state_next    = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_data_reg;
    assign last_out     = out_last_reg;
    assign overflow     = out_ovf_reg;

endmodule

`default_nettype wire

// File: sim/exchange_sort_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exchange_sort_engine_tb
// loads sets of signed words into the sort engine and checks every sorted
// output beat, with its last and overflow marks, against a local model that
// sorts the same sets; runs with and without sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module exchange_sort_engine_tb;

    import esort_pkg::*;

    typedef struct packed {
        word_t val;
        logic  last;
        logic  ovf;
    } sorted_beat_t;

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  in_valid     = 1'b0;
    logic  in_stall;
    word_t value        = '0;
    logic  last_in      = 1'b0;
    logic  out_valid;
    logic  out_stall    = 1'b0;
    word_t sorted_value;
    logic  last_out;
    logic  overflow;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;

    // model of the element store
    word_t held_words [MAX_ELEMS];
    int    held_count   = 0;
    logic  held_dropped = 1'b0;

    sorted_beat_t pending_sorted_q [$];

    exchange_sort_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // store one accepted element; on the closing beat sort and queue the run
    function automatic void load_and_sort(input word_t v, input logic closing);
        sorted_beat_t b;
        word_t        t;
        int           i;
        int           j;
        int           k;
        if (held_count < MAX_ELEMS)
        begin
            held_words[held_count] = v;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (closing)
        begin
            for (i = 0; i + 1 < held_count; i++)
                for (j = i + 1; j < held_count; j++)
                    if (held_words[i] > held_words[j])
                    begin
                        t             = held_words[i];
                        held_words[i] = held_words[j];
                        held_words[j] = t;
                    end
            for (k = 0; k < held_count; k++)
            begin
                b.val  = held_words[k];
                b.last = (k == held_count - 1);
                b.ovf  = held_dropped;
                pending_sorted_q.push_back(b);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endfunction

    // receiver stalls
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // check each output beat against the oldest expected one
    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sorted_q.size() == 0)
                report_mismatch("unexpected sorted beat, value", sorted_value, 0);
            else
            begin
                want = pending_sorted_q.pop_front();
                if (sorted_value !== want.val)
                    report_mismatch("sorted_value", sorted_value, want.val);
                if (last_out !== want.last)
                    report_mismatch("last_out", last_out, want.last);
                if (overflow !== want.ovf)
                    report_mismatch("overflow", overflow, want.ovf);
            end
        end
    end

    task automatic send_beat(input word_t v, input logic closing);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last_in  <= closing;
        do
            @(posedge clk);
        while (in_stall);
        load_and_sort(v, closing);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_sorted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    function automatic word_t rand_word();
        word_t w;
        case ($urandom_range(3))
            0: w = $urandom_range(8) - 4;
            1:
            begin
                case ($urandom_range(3))
                    0: w = 32'sh7FFF_FFFF;
                    1: w = 32'sh8000_0000;
                    2: w = '0;
                    default: w = -1;
                endcase
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_set(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_beat(rand_word(), k == len - 1);
    endtask

    task automatic test_single_element();
        send_beat(32'sh8000_0000, 1'b1);
        send_beat(32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_extreme_values();
        word_t vals [9];
        int    k;
        vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1,
                 32'sh8000_0001, 32'sh7FFF_FFFE, 0, -1};
        for (k = 0; k < 9; k++)
            send_beat(vals[k], k == 8);
    endtask

    task automatic test_ordered_runs();
        int k;
        for (k = 0; k < 5; k++)
            send_beat(k * 1000 - 2000, k == 4);
        for (k = 0; k < 5; k++)
            send_beat(2000 - k * 1000, k == 4);
        for (k = 0; k < 3; k++)
            send_beat(7, k == 2);
    endtask

    // full store, closing beat dropped, and a set well past capacity
    task automatic test_store_capacity();
        send_set(MAX_ELEMS);
        send_set(MAX_ELEMS + 1);
        send_set(MAX_ELEMS + 6);
    endtask

    task automatic test_random_sets(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(MAX_ELEMS + 6, 40);
            else
                len = $urandom_range(12, 1);
            send_set(len);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(0, 0);
        test_single_element();
        test_extreme_values();
        test_ordered_runs();
        test_random_sets(25);
        drain_results();

        set_idling(86, 0);
        test_random_sets(25);
        drain_results();

        set_idling(0, 86);
        test_random_sets(25);
        drain_results();

        set_idling(35, 35);
        test_store_capacity();
        test_random_sets(25);
        drain_results();

        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
design/esort_pkg.sv
design/exchange_sort_engine.sv
sim/exchange_sort_engine_tb.sv
